FILE: rtl/efoc_pkg.sv
// Shared types and constants for the event queue with overflow counter.
package efoc_pkg;

  localparam int unsigned BIND_W     = 16;
  localparam int unsigned GEN_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CAP_W      = 8;
  localparam int unsigned XFER_W     = 5;
  localparam int unsigned OVF_W      = 32;
  localparam int unsigned MAX_XFER   = 16;

  localparam logic CMD_POST  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic post;        // Store the request item or count a refusal.
    logic drain;       // Take transfer count and overflow snapshot.
    logic rd;          // Read the oldest entry and pop it.
    logic load_post;   // Load the post result into the response register.
    logic load_empty;  // Load the drain result that carries no event.
    logic load_event;  // Load a drained event into the response register.
  } efoc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic xfer_zero;   // The drain on the request port would move nothing.
    logic rem_zero;    // No events of the current drain are left to read.
    logic rsp_free;    // The response register can take a new item.
  } efoc_sts_t;

endpackage

FILE: rtl/efoc_ctrl.sv
// Controller state machine that sequences posts and drains.
module efoc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              cmd,
  output logic              req_stall,
  output efoc_pkg::efoc_cmd_t ctl,
  input  efoc_pkg::efoc_sts_t sts
);
  import efoc_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    POST_RSP,
    EMPTY_RSP,
    READ,
    EVENT_RSP
  } state_t;

  state_t state;
  logic   accept;

  assign req_stall = (state != IDLE);
  assign accept    = req_valid && (state == IDLE);

  always_comb begin
    ctl            = '0;
    ctl.post       = accept && (cmd == CMD_POST);
    ctl.drain      = accept && (cmd == CMD_DRAIN);
    ctl.rd         = (state == READ);
    ctl.load_post  = (state == POST_RSP) && sts.rsp_free;
    ctl.load_empty = (state == EMPTY_RSP) && sts.rsp_free;
    ctl.load_event = (state == EVENT_RSP) && sts.rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            if (cmd == CMD_POST) begin
              state <= POST_RSP;
            end else if (sts.xfer_zero) begin
              state <= EMPTY_RSP;
            end else begin
              state <= READ;
            end
          end
        end
        POST_RSP: begin
          if (sts.rsp_free) begin
            state <= IDLE;
          end
        end
        EMPTY_RSP: begin
          if (sts.rsp_free) begin
            state <= IDLE;
          end
        end
        READ: begin
          state <= EVENT_RSP;
        end
        EVENT_RSP: begin
          if (sts.rsp_free) begin
            state <= sts.rem_zero ? IDLE : READ;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/efoc_dp.sv
// Datapath: event memory, pointers, counters and the response register.
module efoc_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  efoc_pkg::efoc_cmd_t         ctl,
  output efoc_pkg::efoc_sts_t         sts,
  input  logic [efoc_pkg::BIND_W-1:0] post_binding,
  input  logic [efoc_pkg::GEN_W-1:0]  generation,
  input  logic [efoc_pkg::TIME_W-1:0] post_time,
  input  logic [efoc_pkg::CAP_W-1:0]  drain_cap,
  input  logic                        rsp_stall,
  output logic                        rsp_valid,
  output logic                        status,
  output logic                        has_event,
  output logic [efoc_pkg::BIND_W-1:0] event_binding,
  output logic [efoc_pkg::GEN_W-1:0]  event_generation,
  output logic [efoc_pkg::TIME_W-1:0] event_time,
  output logic [efoc_pkg::XFER_W-1:0] transfer_count,
  output logic [efoc_pkg::OVF_W-1:0]  refused_count,
  output logic                        last
);
  import efoc_pkg::*;

  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W   = CNT_W + 1;
  localparam int unsigned ENTRY_W = BIND_W + GEN_W + TIME_W;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata;

  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic [OVF_W-1:0]  overflow_total;
  logic [OVF_W-1:0]  ovf_snap;
  logic [XFER_W-1:0] xfer;
  logic [XFER_W-1:0] remaining;
  logic              post_full;

  logic              full;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;
  logic [PTR_W-1:0]  tail;
  logic [CAP_W-1:0]  fill_wide;
  logic [CAP_W-1:0]  cap_min;
  logic [XFER_W-1:0] xfer_next;
  logic              rsp_free;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign tail_sum  = SUM_W'(rd_ptr) + SUM_W'(fill);
  assign tail_wrap = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                     (tail_sum - SUM_W'(QUEUE_DEPTH)) : tail_sum;
  assign tail      = tail_wrap[PTR_W-1:0];

  // Transfer count is the smallest of fill level, drain cap and the result limit.
  assign fill_wide = CAP_W'(fill);
  assign cap_min   = (fill_wide < drain_cap) ? fill_wide : drain_cap;
  assign xfer_next = (cap_min > CAP_W'(MAX_XFER)) ? XFER_W'(MAX_XFER) : cap_min[XFER_W-1:0];

  assign rsp_free      = !rsp_valid || !rsp_stall;
  assign sts.xfer_zero = (xfer_next == '0);
  assign sts.rem_zero  = (remaining == '0);
  assign sts.rsp_free  = rsp_free;

  always_ff @(posedge clk) begin
    if (ctl.post && !full) begin
      mem[tail] <= {post_binding, generation, post_time};
    end
    if (ctl.rd) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr         <= '0;
      fill           <= '0;
      overflow_total <= '0;
    end else begin
      if (ctl.post) begin
        if (full) begin
          overflow_total <= overflow_total + OVF_W'(1);
        end else begin
          fill <= fill + CNT_W'(1);
        end
      end
      if (ctl.drain) begin
        overflow_total <= '0;
      end
      if (ctl.rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        fill   <= fill - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.post) begin
      post_full <= full;
    end
    if (ctl.drain) begin
      xfer      <= xfer_next;
      remaining <= xfer_next;
      ovf_snap  <= overflow_total;
    end
    if (ctl.rd) begin
      remaining <= remaining - XFER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.load_post || ctl.load_empty || ctl.load_event) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_post) begin
      status           <= post_full ? STATUS_FULL : STATUS_OK;
      has_event        <= 1'b0;
      event_binding    <= '0;
      event_generation <= '0;
      event_time       <= '0;
      transfer_count   <= '0;
      refused_count    <= '0;
      last             <= 1'b1;
    end else if (ctl.load_empty) begin
      status           <= STATUS_OK;
      has_event        <= 1'b0;
      event_binding    <= '0;
      event_generation <= '0;
      event_time       <= '0;
      transfer_count   <= '0;
      refused_count    <= ovf_snap;
      last             <= 1'b1;
    end else if (ctl.load_event) begin
      status           <= STATUS_OK;
      has_event        <= 1'b1;
      event_binding    <= rdata[ENTRY_W-1 -: BIND_W];
      event_generation <= rdata[TIME_W +: GEN_W];
      event_time       <= rdata[TIME_W-1:0];
      transfer_count   <= xfer;
      refused_count    <= ovf_snap;
      last             <= (remaining == '0);
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill level exceeds queue depth");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    rd_ptr <= PTR_W'(QUEUE_DEPTH - 1))
    else $error("read pointer out of range");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.rd |-> (fill != '0) && (remaining != '0))
    else $error("read issued with nothing left to pop");

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load_post, ctl.load_empty, ctl.load_event}))
    else $error("more than one response load in a cycle");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_post || ctl.load_empty || ctl.load_event) |-> rsp_free)
    else $error("response register overwritten while held");

endmodule

FILE: rtl/event_fifo_with_overflow_count.sv
// Top level of the event queue with a wrapping overflow counter.
//
// The request channel (req_valid, req_stall) carries one item per handshake:
// cmd selects a post of an event (post_binding, generation, post_time)
// or a drain that pops up to drain_cap of the oldest events, never more than
// sixteen. The response channel (rsp_valid, rsp_stall) returns the result
// items. A post gives one item with status full if the queue had no room, in
// which case the overflow counter is incremented and wraps. A drain gives one
// item per event popped, each carrying the transfer count and the number of
// refused posts since the previous drain, with last set on the final one; a
// drain that moves nothing gives a single item with has_event clear.
//
// A post or an empty drain passes from IDLE to POST_RSP or EMPTY_RSP, where its
// result is loaded into the response register, and the controller then returns
// to IDLE to accept the next item. A drain of events alternates READ, the
// registered memory read, and EVENT_RSP, the response register load, once per
// event, and returns to IDLE after loading its last event. The request side is
// stalled while an item is in progress; a receiver stall holds the response
// register and its payload and holds back the next load. Synchronous reset
// empties the queue, clears the overflow counter and drops a pending response.
module event_fifo_with_overflow_count #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        cmd,
  input  logic [efoc_pkg::BIND_W-1:0] post_binding,
  input  logic [efoc_pkg::GEN_W-1:0]  generation,
  input  logic [efoc_pkg::TIME_W-1:0] post_time,
  input  logic [efoc_pkg::CAP_W-1:0]  drain_cap,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        status,
  output logic                        has_event,
  output logic [efoc_pkg::BIND_W-1:0] event_binding,
  output logic [efoc_pkg::GEN_W-1:0]  event_generation,
  output logic [efoc_pkg::TIME_W-1:0] event_time,
  output logic [efoc_pkg::XFER_W-1:0] transfer_count,
  output logic [efoc_pkg::OVF_W-1:0]  refused_count,
  output logic                        last
);
  import efoc_pkg::*;

  // Command and status buses between the controller and the datapath.
  efoc_cmd_t ctl;
  efoc_sts_t sts;

  efoc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .cmd       (cmd),
    .req_stall (req_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  efoc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctl              (ctl),
    .sts              (sts),
    .post_binding     (post_binding),
    .generation       (generation),
    .post_time        (post_time),
    .drain_cap        (drain_cap),
    .rsp_stall        (rsp_stall),
    .rsp_valid        (rsp_valid),
    .status           (status),
    .has_event        (has_event),
    .event_binding    (event_binding),
    .event_generation (event_generation),
    .event_time       (event_time),
    .transfer_count   (transfer_count),
    .refused_count    (refused_count),
    .last             (last)
  );

endmodule

FILE: dv/event_fifo_with_overflow_count_tb.sv
// Self-checking testbench for the event queue with a wrapping overflow counter.
module event_fifo_with_overflow_count_tb;
  import efoc_pkg::*;

  // The block is built at its default depth, and the predictor uses the same depth.
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  // A quiet stretch this long means the block has hung. A correct run never comes
  // near it, even with long random stalls.
  localparam int QUIET_LIMIT = 2000;
  // After the last result, allow time for a full sixteen-event drain and a margin,
  // so that any stray extra result is still caught.
  localparam int SETTLE_CYCLES = 40;

  // How each stretch of the run idles its two sides.
  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SENDER_GAPS,
    PH_RECEIVER_STALLS,
    PH_MIXED
  } phase_t;

  // One request item, with the idling phase it belongs to and a flag that makes
  // the sender wait until every owed result has come back.
  typedef struct packed {
    logic              cmd;
    logic [BIND_W-1:0] post_binding;
    logic [GEN_W-1:0]  generation;
    logic [TIME_W-1:0] post_time;
    logic [CAP_W-1:0]  drain_cap;
    phase_t            phase;
    logic              hold;
  } req_item_t;

  // One result item, laid out field by field as the response ports show it.
  typedef struct packed {
    logic              status;
    logic              has_event;
    logic [BIND_W-1:0] event_binding;
    logic [GEN_W-1:0]  event_generation;
    logic [TIME_W-1:0] event_time;
    logic [XFER_W-1:0] transfer_count;
    logic [OVF_W-1:0]  refused_count;
    logic              last;
  } evt_result_t;

  // Every input starts at a known value, before reset has even been sampled.
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic              cmd = CMD_POST;
  logic [BIND_W-1:0] post_binding = '0;
  logic [GEN_W-1:0]  generation = '0;
  logic [TIME_W-1:0] post_time = '0;
  logic [CAP_W-1:0]  drain_cap = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic              status;
  logic              has_event;
  logic [BIND_W-1:0] event_binding;
  logic [GEN_W-1:0]  event_generation;
  logic [TIME_W-1:0] event_time;
  logic [XFER_W-1:0] transfer_count;
  logic [OVF_W-1:0]  refused_count;
  logic              last;

  event_fifo_with_overflow_count #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  // Stimulus waiting to be offered, and the results the predictor says are owed.
  req_item_t   pending_reqs[$];
  evt_result_t owed_results[$];
  req_item_t   active_req;
  evt_result_t want;

  // The results_owed counter is written by the driver and results_seen by the
  // monitor. results_seen is updated with a nonblocking assignment, so the driver
  // always reads the value from before the edge.
  int     results_owed = 0;
  int     results_seen = 0;
  int     mismatch_count = 0;
  int     quiet_cycles = 0;
  phase_t cur_phase = PH_STEADY;

  // The predictor's own copy of the queue state.
  logic [BIND_W-1:0] store_binding[DEPTH];
  logic [GEN_W-1:0]  store_generation[DEPTH];
  logic [TIME_W-1:0] store_time[DEPTH];
  logic [PTR_W-1:0]  head_ptr = '0;
  logic [XFER_W-1:0] queued = '0;
  logic [OVF_W-1:0]  refused_total = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int sender_idle_pct(input phase_t ph);
    case (ph)
      PH_SENDER_GAPS: return 67;
      PH_MIXED:       return 25;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input phase_t ph);
    case (ph)
      PH_RECEIVER_STALLS: return 67;
      PH_MIXED:           return 25;
      default:            return 0;
    endcase
  endfunction

  // Applies one accepted request item to the predicted queue state and appends
  // the result items it must produce.
  function automatic void predict_queue_results(input req_item_t r);
    evt_result_t      res;
    logic [PTR_W-1:0] tail;
    int               take;
    logic [OVF_W-1:0] snapshot;
    res = '0;
    res.status = STATUS_OK;
    res.last = 1'b1;
    if (r.cmd == CMD_POST) begin
      if (int'(queued) >= DEPTH) begin
        // A full queue refuses the post, and the refusal counter wraps at 32 bits.
        res.status = STATUS_FULL;
        refused_total = refused_total + 1'b1;
      end else begin
        tail = head_ptr + queued[PTR_W-1:0];
        store_binding[tail] = r.post_binding;
        store_generation[tail] = r.generation;
        store_time[tail] = r.post_time;
        queued = queued + 1'b1;
      end
      owed_results.push_back(res);
      results_owed++;
    end else begin
      // A drain moves the smallest of the fill level, the cap and sixteen. The
      // refusal total goes out with every item of the drain and is then cleared.
      take = int'(queued);
      if (take > int'(r.drain_cap)) take = int'(r.drain_cap);
      if (take > int'(MAX_XFER)) take = int'(MAX_XFER);
      snapshot = refused_total;
      refused_total = '0;
      res.refused_count = snapshot;
      if (take == 0) begin
        // With nothing to move, a single item carries only the refusal total.
        owed_results.push_back(res);
        results_owed++;
      end else begin
        for (int i = 0; i < take; i++) begin
          res.has_event = 1'b1;
          res.event_binding = store_binding[head_ptr];
          res.event_generation = store_generation[head_ptr];
          res.event_time = store_time[head_ptr];
          res.transfer_count = XFER_W'(take);
          res.last = (i == take - 1);
          owed_results.push_back(res);
          results_owed++;
          head_ptr = head_ptr + 1'b1;
        end
        queued = queued - XFER_W'(take);
      end
    end
  endfunction

  task automatic add_item(input logic op, input logic [BIND_W-1:0] b,
                          input logic [GEN_W-1:0] g, input logic [TIME_W-1:0] ts,
                          input logic [CAP_W-1:0] cap, input phase_t ph,
                          input logic hold);
    req_item_t r;
    r.cmd = op;
    r.post_binding = b;
    r.generation = g;
    r.post_time = ts;
    r.drain_cap = cap;
    r.phase = ph;
    r.hold = hold;
    pending_reqs.push_back(r);
  endtask

  // Random traffic for one idling phase. Most of it is bursts of posts, which
  // often run the queue into the full state, and drains with caps mostly from one
  // to eighteen. The rest is noise with every field random. The first item of
  // the phase waits until the block has returned all owed results.
  task automatic add_random(input phase_t ph, input int count);
    int               made;
    int               len;
    int               pick;
    logic [CAP_W-1:0] cap;
    made = 0;
    while (made < count) begin
      pick = int'($urandom_range(99));
      if (pick < 45) begin
        len = int'($urandom_range(1, 20));
        repeat (len) begin
          add_item(CMD_POST, 16'($urandom()), 16'($urandom()), $urandom(),
                   8'($urandom()), ph, made == 0);
          made++;
        end
      end else if (pick < 85) begin
        pick = int'($urandom_range(99));
        if (pick < 10) cap = '0;
        else if (pick < 20) cap = '1;
        else if (pick < 35) cap = 8'($urandom());
        else cap = 8'($urandom_range(1, 18));
        add_item(CMD_DRAIN, 16'($urandom()), 16'($urandom()), $urandom(), cap, ph,
                 made == 0);
        made++;
      end else begin
        add_item(1'($urandom()), 16'($urandom()), 16'($urandom()), $urandom(),
                 8'($urandom()), ph, made == 0);
        made++;
      end
    end
  endtask

  // When the channel is free, the driver offers the next pending item unless it
  // idles or holds. Once an item is raised, it stays unchanged until taken.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        predict_queue_results(active_req);
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0 &&
            !(pending_reqs[0].hold && results_seen != results_owed) &&
            int'($urandom_range(99)) >= sender_idle_pct(pending_reqs[0].phase)) begin
          active_req = pending_reqs.pop_front();
          req_valid <= 1'b1;
          cmd <= active_req.cmd;
          post_binding <= active_req.post_binding;
          generation <= active_req.generation;
          post_time <= active_req.post_time;
          drain_cap <= active_req.drain_cap;
          cur_phase <= active_req.phase;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor checks every accepted result against the oldest owed one, field
  // by field, and stalls the response side at random as the phase dictates.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          report_error("result item arrived with none expected");
        end else begin
          want = owed_results.pop_front();
          if (status !== want.status)
            report_error($sformatf("status: got %0h, expected %0h", status, want.status));
          if (has_event !== want.has_event)
            report_error($sformatf("has_event: got %0h, expected %0h",
                                   has_event, want.has_event));
          if (event_binding !== want.event_binding)
            report_error($sformatf("event_binding: got %0h, expected %0h",
                                   event_binding, want.event_binding));
          if (event_generation !== want.event_generation)
            report_error($sformatf("event_generation: got %0h, expected %0h",
                                   event_generation, want.event_generation));
          if (event_time !== want.event_time)
            report_error($sformatf("event_time: got %0h, expected %0h",
                                   event_time, want.event_time));
          if (transfer_count !== want.transfer_count)
            report_error($sformatf("transfer_count: got %0d, expected %0d",
                                   transfer_count, want.transfer_count));
          if (refused_count !== want.refused_count)
            report_error($sformatf("refused_count: got %0d, expected %0d",
                                   refused_count, want.refused_count));
          if (last !== want.last)
            report_error($sformatf("last: got %0h, expected %0h", last, want.last));
        end
      end
      rsp_stall <= int'($urandom_range(99)) < receiver_stall_pct(cur_phase);
    end
  end

  // The watchdog ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ERROR at %0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("** event_fifo_with_overflow_count: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // Directed part. A drain with the largest cap runs on the empty queue. Posts
    // carry the all-zero and all-one field extremes. A cap of zero is tried with
    // events queued. The queue is filled to the brim, posts are refused while it
    // is full, and then all sixteen entries go out in a single drain.
    add_item(CMD_DRAIN, '1, '1, '1, '1, PH_STEADY, 1'b0);
    add_item(CMD_POST, '0, '0, '0, '0, PH_STEADY, 1'b0);
    add_item(CMD_POST, '1, '1, '1, '1, PH_STEADY, 1'b0);
    add_item(CMD_DRAIN, '0, '0, '0, '0, PH_STEADY, 1'b0);
    add_item(CMD_DRAIN, '0, '0, '0, 8'd1, PH_STEADY, 1'b0);
    add_item(CMD_DRAIN, '0, '0, '0, '1, PH_STEADY, 1'b0);
    repeat (DEPTH) begin
      add_item(CMD_POST, 16'($urandom()), 16'($urandom()), $urandom(), 8'($urandom()),
               PH_STEADY, 1'b0);
    end
    add_item(CMD_POST, '1, '0, '1, '0, PH_STEADY, 1'b0);
    add_item(CMD_POST, '0, '1, '0, '1, PH_STEADY, 1'b0);
    // This drain waits for the block to go quiet, so the refusals are in place.
    add_item(CMD_DRAIN, '0, '0, '0, '0, PH_STEADY, 1'b1);
    add_item(CMD_POST, 16'h8000, 16'h0001, 32'h8000_0001, '0, PH_STEADY, 1'b0);
    add_item(CMD_DRAIN, '0, '0, '0, '1, PH_STEADY, 1'b0);
    add_item(CMD_DRAIN, '0, '0, '0, '1, PH_STEADY, 1'b0);

    // Random part, one stretch for each idling pattern.
    add_random(PH_STEADY, 96);
    add_random(PH_SENDER_GAPS, 96);
    add_random(PH_RECEIVER_STALLS, 96);
    add_random(PH_MIXED, 96);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Wait until every item has been taken and every owed result has come, then
    // allow the block time to show any result that nobody asked for.
    while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
    while (results_seen != results_owed) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0)
      report_error($sformatf("%0d expected result items never arrived",
                             owed_results.size()));

    if (mismatch_count == 0) begin
      $display("** event_fifo_with_overflow_count: PASSED **");
    end else begin
      $display("** event_fifo_with_overflow_count: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/efoc_pkg.sv
rtl/efoc_ctrl.sv
rtl/efoc_dp.sv
rtl/event_fifo_with_overflow_count.sv
dv/event_fifo_with_overflow_count_tb.sv
